@@ sv/msgm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msgm_pkg
// Shared types, constants and helpers of the mic sample gain mixer.
// ----------------------------------------------------------------------------
package msgm_pkg;

    localparam int ADC_LANES   = 4;
    localparam int ADC_W       = 12;
    localparam int I2S_W       = 32;
    localparam int I2S_SHIFT   = 11;
    localparam int WORD_W      = I2S_W - I2S_SHIFT;
    localparam int ADC_UP_SH   = 4;
    localparam int PCM_W       = 16;
    localparam int PCM_FULL    = 32768;
    localparam int PCM_TOP     = 32767;
    localparam int GAIN_W      = 8;
    localparam int GAIN_SLOTS  = 4;
    localparam int MULT_W      = GAIN_W + 2;
    localparam int WEIGHT_W    = 7;
    localparam int WEIGHT_FULL = 100;
    localparam int VOL_W       = 7;
    localparam int VOL_MUL     = 100;
    localparam int VOL_SH      = 15;
    localparam int VOL_PROD_W  = PCM_W + VOL_W;
    localparam int CNT_W       = $clog2(ADC_LANES + 1);
    localparam int SAT_IN_W    = 32;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // lane average: magnitude times reciprocal
    localparam int SUM_W       = PCM_W + $clog2(ADC_LANES) + 1;
    localparam int DIV_SH      = SUM_W + CNT_W;
    localparam int RECIP_W     = DIV_SH + 1;
    localparam int DIV_PROD_W  = SUM_W + RECIP_W;
    localparam longint DIV_ONE = longint'(1) << DIV_SH;
    localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(DIV_ONE);
    localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((DIV_ONE + 1) / 2);
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((DIV_ONE + 2) / 3);
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((DIV_ONE + 3) / 4);
    localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((DIV_ONE + 4) / 5);
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((DIV_ONE + 5) / 6);
    localparam logic [RECIP_W-1:0] RECIP_7 = RECIP_W'((DIV_ONE + 6) / 7);
    localparam logic [RECIP_W-1:0] RECIP_8 = RECIP_W'((DIV_ONE + 7) / 8);

    // blend: divide by 100 through a reciprocal
    localparam int BLEND_W       = PCM_W + WEIGHT_W + 2;
    localparam int BLEND_MAG_W   = 22;
    localparam int BLEND_SH      = 29;
    localparam int BLEND_RECIP_W = 23;
    localparam int BLEND_PROD_W  = BLEND_MAG_W + BLEND_RECIP_W;
    localparam longint BLEND_ONE = longint'(1) << BLEND_SH;
    localparam logic [BLEND_RECIP_W-1:0] BLEND_RECIP =
        BLEND_RECIP_W'((BLEND_ONE + WEIGHT_FULL - 1) / WEIGHT_FULL);

    localparam logic signed [SAT_IN_W-1:0] SAT_LO = SAT_IN_W'(-PCM_FULL);
    localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'(PCM_TOP);

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO_OUT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIC_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIC_GAINS    = 3'd5;

    typedef enum logic [1:0] {
        MODE_I2S    = 2'd0,
        MODE_ADC    = 2'd1,
        MODE_HYBRID = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]                         source_mode;
        logic                               stereo_out;
        logic [GAIN_W-1:0]                  master_gain;
        logic [WEIGHT_W-1:0]                blend_weight;
        logic [2:0]                         mic_count;
        logic [GAIN_SLOTS*GAIN_W-1:0]       mic_gains;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        source_mode:  2'd0,
        stereo_out:   1'b0,
        master_gain:  8'd6,
        blend_weight: 7'd60,
        mic_count:    3'd1,
        mic_gains:    32'h0606_0606
    };

    typedef struct packed {
        t_mode                              mode;
        logic                               stereo;
        logic                               chunk_end;
        logic [CNT_W-1:0]                   mic_cnt;
        logic signed [WORD_W-1:0]           left_w;
        logic signed [WORD_W-1:0]           right_w;
        logic [ADC_LANES-1:0][PCM_W-1:0]    lane_c;
    } t_job;

    function automatic logic signed [PCM_W-1:0] sat_pcm(input logic signed [SAT_IN_W-1:0] v);
        logic signed [PCM_W-1:0] r;
        if (v < SAT_LO) begin
            r = SAT_LO[PCM_W-1:0];
        end else if (v > SAT_HI) begin
            r = SAT_HI[PCM_W-1:0];
        end else begin
            r = v[PCM_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [PCM_W-1:0] abs_pcm(input logic signed [PCM_W-1:0] v);
        logic [PCM_W-1:0] r;
        r = v[PCM_W-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

    function automatic logic [RECIP_W-1:0] lane_recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        case (int'(cnt))
            1: r = RECIP_1;
            2: r = RECIP_2;
            3: r = RECIP_3;
            4: r = RECIP_4;
            5: r = RECIP_5;
            6: r = RECIP_6;
            7: r = RECIP_7;
            8: r = RECIP_8;
            default: r = RECIP_1;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/msgm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msgm_front
// Frame intake: decode mode and lane count, align I2S words, center ADC lanes.
// ----------------------------------------------------------------------------
module msgm_front (
    input  msgm_pkg::t_cfg                          i_cfg,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [msgm_pkg::I2S_W-1:0]       i_i2s_left,
    input  logic signed [msgm_pkg::I2S_W-1:0]       i_i2s_right,
    input  logic [msgm_pkg::ADC_W-1:0]              i_adc_sample_0,
    input  logic [msgm_pkg::ADC_W-1:0]              i_adc_sample_1,
    input  logic [msgm_pkg::ADC_W-1:0]              i_adc_sample_2,
    input  logic [msgm_pkg::ADC_W-1:0]              i_adc_sample_3,
    input  logic                                    i_chunk_end,
    input  logic                                    i_full,
    output logic                                    o_push,
    output msgm_pkg::t_job                          o_job
);
    import msgm_pkg::*;

    logic [ADC_LANES-1:0][ADC_W-1:0] samples;
    t_mode                           mode;
    logic [CNT_W-1:0]                cnt;

    assign samples = {i_adc_sample_3, i_adc_sample_2, i_adc_sample_1, i_adc_sample_0};

    always_comb begin
        case (i_cfg.source_mode)
            MODE_ADC:    mode = MODE_ADC;
            MODE_HYBRID: mode = MODE_HYBRID;
            default:     mode = MODE_I2S;
        endcase
    end

    always_comb begin
        if (i_cfg.mic_count == '0) begin
            cnt = CNT_W'(1);
        end else if (CNT_W'(i_cfg.mic_count) > CNT_W'(ADC_LANES)) begin
            cnt = CNT_W'(ADC_LANES);
        end else begin
            cnt = CNT_W'(i_cfg.mic_count);
        end
    end

    always_comb begin
        o_job.mode      = mode;
        o_job.stereo    = (mode == MODE_I2S) && i_cfg.stereo_out;
        o_job.chunk_end = i_chunk_end;
        o_job.mic_cnt   = cnt;
        o_job.left_w    = i_i2s_left[I2S_W-1:I2S_SHIFT];
        o_job.right_w   = i_i2s_right[I2S_W-1:I2S_SHIFT];
        for (int m = 0; m < ADC_LANES; m++) begin
            o_job.lane_c[m] = {~samples[m][ADC_W-1], samples[m][ADC_W-2:0],
                               ADC_UP_SH'(0)};
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule
`default_nettype wire

@@ sv/msgm_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msgm_queue
// Short job queue between frame intake and the mixing sequencer.
// ----------------------------------------------------------------------------
module msgm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  msgm_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output msgm_pkg::t_job  o_job
);
    import msgm_pkg::*;

    t_job               r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        logic [Q_PTR_W-1:0] r;
        r = (p == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_full  = (r_count == Q_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

@@ sv/msgm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msgm_back
// Mixing sequencer: gains, lane average, master gain, blend, peak and output.
// ----------------------------------------------------------------------------
module msgm_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  msgm_pkg::t_cfg                      i_cfg,
    input  logic                                i_job_valid,
    input  msgm_pkg::t_job                      i_job,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [msgm_pkg::PCM_W-1:0]   o_pcm_sample,
    output logic                                o_last_of_frame,
    output logic                                o_chunk_done,
    output logic [msgm_pkg::VOL_W-1:0]          o_volume_level
);
    import msgm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_COMBINE,
        S_DIVIDE,
        S_GAIN,
        S_BLEND,
        S_NORM,
        S_EMIT_LEFT,
        S_EMIT
    } t_state;

    localparam int WPROD_W = WORD_W + MULT_W;
    localparam int LPROD_W = PCM_W + MULT_W;

    t_state                           r_state;
    logic                             r_out_valid;
    logic [PCM_W-1:0]                 r_peak;

    t_job                             r_job;
    logic signed [PCM_W-1:0]          r_left;
    logic signed [PCM_W-1:0]          r_right;
    logic [ADC_LANES-1:0][PCM_W-1:0]  r_lane;
    logic signed [PCM_W-1:0]          r_mono;
    logic [SUM_W-1:0]                 r_sum_mag;
    logic                             r_sum_neg;
    logic signed [PCM_W-1:0]          r_avg;
    logic signed [PCM_W-1:0]          r_adc;
    logic [BLEND_MAG_W-1:0]           r_bl_mag;
    logic                             r_bl_neg;
    logic signed [PCM_W-1:0]          r_res;
    logic signed [PCM_W-1:0]          r_pcm;
    logic                             r_last;
    logic                             r_chunk;
    logic [VOL_W-1:0]                 r_vol;

    logic                             out_free;
    logic                             emit_now;
    logic signed [MULT_W-1:0]         master_mult;
    logic signed [WPROD_W-1:0]        left_prod;
    logic signed [WPROD_W-1:0]        right_prod;
    logic [ADC_LANES-1:0][PCM_W-1:0]  lane_sat;
    logic signed [PCM_W:0]            lr_sum;
    logic signed [PCM_W:0]            lr_adj;
    logic signed [PCM_W-1:0]          mono;
    logic signed [SUM_W-1:0]          lane_sum;
    logic [DIV_PROD_W-1:0]            div_prod;
    logic [PCM_W:0]                   div_q;
    logic signed [PCM_W:0]            avg_s;
    logic signed [LPROD_W-1:0]        gain_prod;
    logic signed [PCM_W-1:0]          adc_next;
    logic [PCM_W-1:0]                 adc_mag;
    logic [PCM_W-1:0]                 left_mag;
    logic [WEIGHT_W-1:0]              weight;
    logic [WEIGHT_W-1:0]              weight_c;
    logic signed [BLEND_W-1:0]        bl_a;
    logic signed [BLEND_W-1:0]        bl_b;
    logic signed [BLEND_W-1:0]        bl_sum;
    logic [BLEND_W-1:0]               bl_abs;
    logic [BLEND_PROD_W-1:0]          norm_prod;
    logic [PCM_W:0]                   norm_q;
    logic signed [PCM_W:0]            norm_s;
    logic signed [PCM_W-1:0]          blend_res;
    logic [VOL_PROD_W-1:0]            vol_prod;

    function automatic logic signed [PCM_W:0] PCM_PLUS1(input logic signed [PCM_W-1:0] v);
        logic signed [PCM_W:0] r;
        r = (PCM_W + 1)'(v);
        return r;
    endfunction

    assign out_free = !r_out_valid || i_ready;
    assign emit_now = out_free && ((r_state == S_EMIT_LEFT) || (r_state == S_EMIT));
    assign o_pop    = i_job_valid &&
                      ((r_state == S_IDLE) || ((r_state == S_EMIT) && out_free));

    assign master_mult = $signed({2'b00, i_cfg.master_gain} + MULT_W'(1));
    assign left_prod   = r_job.left_w * master_mult;
    assign right_prod  = r_job.right_w * master_mult;

    for (genvar m = 0; m < ADC_LANES; m++) begin : g_lane
        logic signed [MULT_W-1:0]  lane_mult;
        logic signed [LPROD_W-1:0] lane_prod;
        assign lane_mult = $signed({2'b00,
                           i_cfg.mic_gains[GAIN_W*(m % GAIN_SLOTS) +: GAIN_W]} + MULT_W'(1));
        assign lane_prod = $signed(r_job.lane_c[m]) * lane_mult;
        assign lane_sat[m] = sat_pcm(SAT_IN_W'(lane_prod));
    end

    always_comb begin
        lr_sum = PCM_PLUS1(r_left) + PCM_PLUS1(r_right);
        lr_adj = lr_sum + (PCM_W + 1)'(lr_sum[PCM_W]);
        mono   = lr_adj[PCM_W:1];
    end

    always_comb begin
        lane_sum = '0;
        for (int m = 0; m < ADC_LANES; m++) begin
            if (CNT_W'(m) < r_job.mic_cnt) begin
                lane_sum = lane_sum + SUM_W'($signed(r_lane[m]));
            end
        end
    end

    always_comb begin
        div_prod = DIV_PROD_W'(r_sum_mag) * DIV_PROD_W'(lane_recip(r_job.mic_cnt));
        div_q    = div_prod[DIV_SH +: PCM_W + 1];
        avg_s    = r_sum_neg ? -$signed(div_q) : $signed(div_q);
    end

    assign gain_prod = r_avg * master_mult;
    assign adc_next  = sat_pcm(SAT_IN_W'(gain_prod));
    assign adc_mag   = abs_pcm(adc_next);
    assign left_mag  = abs_pcm(r_left);

    always_comb begin
        weight   = (i_cfg.blend_weight > WEIGHT_W'(WEIGHT_FULL)) ?
                   WEIGHT_W'(WEIGHT_FULL) : i_cfg.blend_weight;
        weight_c = WEIGHT_W'(WEIGHT_FULL) - weight;
        bl_a     = r_mono * $signed({1'b0, weight});
        bl_b     = r_adc * $signed({1'b0, weight_c});
        bl_sum   = bl_a + bl_b;
        bl_abs   = bl_sum[BLEND_W-1] ? BLEND_W'(-bl_sum) : BLEND_W'(bl_sum);
    end

    always_comb begin
        norm_prod = BLEND_PROD_W'(r_bl_mag) * BLEND_PROD_W'(BLEND_RECIP);
        norm_q    = norm_prod[BLEND_SH +: PCM_W + 1];
        norm_s    = r_bl_neg ? -$signed(norm_q) : $signed(norm_q);
        blend_res = sat_pcm(SAT_IN_W'(norm_s));
    end

    assign vol_prod = VOL_PROD_W'(r_peak) * VOL_PROD_W'(VOL_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_peak      <= '0;
        end else begin
            r_out_valid <= emit_now || (r_out_valid && !i_ready);
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_state <= S_COMBINE;
                end
                S_COMBINE: begin
                    if (r_job.mode == MODE_I2S) begin
                        if (left_mag > r_peak) begin
                            r_peak <= left_mag;
                        end
                        r_state <= r_job.stereo ? S_EMIT_LEFT : S_EMIT;
                    end else begin
                        r_state <= S_DIVIDE;
                    end
                end
                S_DIVIDE: begin
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    if (adc_mag > r_peak) begin
                        r_peak <= adc_mag;
                    end
                    r_state <= (r_job.mode == MODE_ADC) ? S_EMIT : S_BLEND;
                end
                S_BLEND: begin
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    r_state <= S_EMIT;
                end
                S_EMIT_LEFT: begin
                    if (out_free) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_job.chunk_end) begin
                            r_peak <= '0;
                        end
                        r_state <= o_pop ? S_SCALE : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        case (r_state)
            S_SCALE: begin
                r_left  <= sat_pcm(SAT_IN_W'(left_prod));
                r_right <= sat_pcm(SAT_IN_W'(right_prod));
                r_lane  <= lane_sat;
            end
            S_COMBINE: begin
                r_mono    <= mono;
                r_sum_neg <= lane_sum[SUM_W-1];
                r_sum_mag <= lane_sum[SUM_W-1] ? SUM_W'(-lane_sum) : SUM_W'(lane_sum);
                r_res     <= r_job.stereo ? r_right : mono;
            end
            S_DIVIDE: begin
                r_avg <= avg_s[PCM_W-1:0];
            end
            S_GAIN: begin
                r_adc <= adc_next;
                r_res <= adc_next;
            end
            S_BLEND: begin
                r_bl_neg <= bl_sum[BLEND_W-1];
                r_bl_mag <= bl_abs[BLEND_MAG_W-1:0];
            end
            S_NORM: begin
                r_res <= blend_res;
            end
            S_EMIT_LEFT: begin
                if (out_free) begin
                    r_pcm   <= r_left;
                    r_last  <= 1'b0;
                    r_chunk <= 1'b0;
                    r_vol   <= '0;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_pcm   <= r_res;
                    r_last  <= 1'b1;
                    r_chunk <= r_job.chunk_end;
                    r_vol   <= r_job.chunk_end ? vol_prod[VOL_SH +: VOL_W] : '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_pcm_sample    = r_pcm;
    assign o_last_of_frame = r_last;
    assign o_chunk_done    = r_chunk;
    assign o_volume_level  = r_vol;

endmodule
`default_nettype wire

@@ sv/mic_sample_gain_mixer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mic_sample_gain_mixer_core
// Mixes one audio frame (I2S pair plus ADC mic lanes) into 16-bit PCM words.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  cfg       i_cfg_wr_en             i_cfg_index, i_cfg_data
//  frame     i_valid / o_ready       i_i2s_left .. i_chunk_end
//  pcm       o_valid / i_ready       o_pcm_sample .. o_volume_level
//
//  Sequencer steps per frame: scale, combine, then emit (I2S stereo emits
//  left first); ADC adds divide and gain, hybrid also blend and normalize.
//  Intake runs ahead of the sequencer through a two-word queue.
//  Reset is synchronous, active low; it restores the register defaults and
//  clears the peak. A stalled pcm word holds the sequencer in its emit state.
// ----------------------------------------------------------------------------
module mic_sample_gain_mixer_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [msgm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [msgm_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [msgm_pkg::I2S_W-1:0]       i_i2s_left,
    input  logic signed [msgm_pkg::I2S_W-1:0]       i_i2s_right,
    input  logic [msgm_pkg::ADC_W-1:0]              i_adc_sample_0,
    input  logic [msgm_pkg::ADC_W-1:0]              i_adc_sample_1,
    input  logic [msgm_pkg::ADC_W-1:0]              i_adc_sample_2,
    input  logic [msgm_pkg::ADC_W-1:0]              i_adc_sample_3,
    input  logic                                    i_chunk_end,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [msgm_pkg::PCM_W-1:0]       o_pcm_sample,
    output logic                                    o_last_of_frame,
    output logic                                    o_chunk_done,
    output logic [msgm_pkg::VOL_W-1:0]              o_volume_level
);
    import msgm_pkg::*;

    t_cfg  r_cfg;
    t_job  front_job;
    t_job  queue_job;
    logic  push;
    logic  full;
    logic  queue_valid;
    logic  pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SOURCE_MODE:  r_cfg.source_mode  <= i_cfg_data[1:0];
                REG_STEREO_OUT:   r_cfg.stereo_out   <= i_cfg_data[0];
                REG_MASTER_GAIN:  r_cfg.master_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_BLEND_WEIGHT: r_cfg.blend_weight <= i_cfg_data[WEIGHT_W-1:0];
                REG_MIC_COUNT:    r_cfg.mic_count    <= i_cfg_data[2:0];
                REG_MIC_GAINS:    r_cfg.mic_gains    <= i_cfg_data[GAIN_SLOTS*GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    msgm_front u_front (
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_i2s_left     (i_i2s_left),
        .i_i2s_right    (i_i2s_right),
        .i_adc_sample_0 (i_adc_sample_0),
        .i_adc_sample_1 (i_adc_sample_1),
        .i_adc_sample_2 (i_adc_sample_2),
        .i_adc_sample_3 (i_adc_sample_3),
        .i_chunk_end    (i_chunk_end),
        .i_full         (full),
        .o_push         (push),
        .o_job          (front_job)
    );

    msgm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_job   (queue_job)
    );

    msgm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_job_valid     (queue_valid),
        .i_job           (queue_job),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pcm_sample    (o_pcm_sample),
        .o_last_of_frame (o_last_of_frame),
        .o_chunk_done    (o_chunk_done),
        .o_volume_level  (o_volume_level)
    );

    a_chunk_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_chunk_done |-> o_last_of_frame)
        else $error("chunk level on a word that does not close its frame");

    a_volume_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_chunk_done |-> o_volume_level == '0)
        else $error("volume level set outside chunk end");

    a_volume_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_volume_level <= VOL_W'(VOL_MUL))
        else $error("volume level above full scale");

    a_left_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_frame |->
            r_cfg.stereo_out && (r_cfg.source_mode != MODE_ADC) &&
            (r_cfg.source_mode != MODE_HYBRID))
        else $error("left word outside I2S stereo mode");

    a_right_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_frame |=> o_valid && o_last_of_frame)
        else $error("right word does not follow left word");

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives audio frames through mic_sample_gain_mixer_core under random
// register settings and random stalls on both channels. It mirrors the gain,
// averaging, blending and peak logic in a small class and compares every pcm
// word with the oldest word that the mirror holds.
// ----------------------------------------------------------------------------
module tb;

    import msgm_pkg::*;

    localparam int RANDOM_FRAMES = 1450;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;

    typedef struct packed {
        logic signed [I2S_W-1:0]           left;
        logic signed [I2S_W-1:0]           right;
        logic [ADC_LANES-1:0][ADC_W-1:0]   adc;
        logic                              chunk_end;
    } t_frame;

    typedef struct packed {
        logic signed [PCM_W-1:0] pcm;
        logic                    last;
        logic                    chunk_done;
        logic [VOL_W-1:0]        volume;
    } t_pcm_word;

    class mixer_mirror;
        logic [1:0]             src_mode;
        logic                   stereo;
        logic [GAIN_W-1:0]      gain;
        logic [WEIGHT_W-1:0]    weight;
        logic [2:0]             mics;
        logic [31:0]            lane_gains;
        longint                 peak;
        t_pcm_word              pending_words[$];
        int                     errors;
        int                     reported;

        function new();
            src_mode   = CFG_RESET.source_mode;
            stereo     = CFG_RESET.stereo_out;
            gain       = CFG_RESET.master_gain;
            weight     = CFG_RESET.blend_weight;
            mics       = CFG_RESET.mic_count;
            lane_gains = CFG_RESET.mic_gains;
            peak       = 0;
            errors     = 0;
            reported   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SOURCE_MODE:  src_mode   = val[1:0];
                REG_STEREO_OUT:   stereo     = val[0];
                REG_MASTER_GAIN:  gain       = val[GAIN_W-1:0];
                REG_BLEND_WEIGHT: weight     = val[WEIGHT_W-1:0];
                REG_MIC_COUNT:    mics       = val[2:0];
                REG_MIC_GAINS:    lane_gains = val;
                default: ;
            endcase
        endfunction

        function longint clip16(longint v);
            if (v < -PCM_FULL) return -PCM_FULL;
            if (v > PCM_TOP) return PCM_TOP;
            return v;
        endfunction

        function longint scaled(longint v, logic [GAIN_W-1:0] g);
            return clip16(v * (1 + longint'(g)));
        endfunction

        function void track(longint v);
            longint mag;
            mag = (v < 0) ? -v : v;
            if (mag > peak) peak = mag;
        endfunction

        function void note_frame(t_frame f);
            t_mode     mode;
            longint    left, right, mono, adc, sum, lanes, w, pcm;
            t_pcm_word wd;
            mode  = (src_mode == 2'd3) ? MODE_I2S : t_mode'(src_mode);
            left  = scaled(longint'(f.left) >>> I2S_SHIFT, gain);
            right = scaled(longint'(f.right) >>> I2S_SHIFT, gain);
            mono  = (left + right) / 2;
            adc   = 0;
            if (mode != MODE_I2S) begin
                lanes = (mics == 0) ? 1 : (mics > ADC_LANES) ? ADC_LANES : mics;
                sum   = 0;
                for (int m = 0; m < lanes; m++) begin
                    sum += scaled((longint'(f.adc[m]) - 2048) * 16,
                                  lane_gains[8*(m%GAIN_SLOTS) +: 8]);
                end
                adc = scaled(sum / lanes, gain);
                track(adc);
            end else begin
                track(left);
            end
            if (mode == MODE_I2S) begin
                if (stereo) begin
                    wd = '{PCM_W'(left), 1'b0, 1'b0, '0};
                    pending_words.push_back(wd);
                    pcm = right;
                end else begin
                    pcm = mono;
                end
            end else if (mode == MODE_ADC) begin
                pcm = adc;
            end else begin
                w   = (weight > WEIGHT_FULL) ? WEIGHT_FULL : weight;
                pcm = clip16((mono * w + adc * (WEIGHT_FULL - w)) / WEIGHT_FULL);
            end
            wd = '{PCM_W'(pcm), 1'b1, 1'b0, '0};
            if (f.chunk_end) begin
                wd.chunk_done = 1'b1;
                wd.volume     = VOL_W'(peak * VOL_MUL / PCM_FULL);
                peak          = 0;
            end
            pending_words.push_back(wd);
        endfunction

        function void check_word(t_pcm_word got);
            t_pcm_word want;
            if (pending_words.size() == 0) begin
                errors++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("unexpected pcm word: pcm=%0d last=%0b chunk=%0b vol=%0d",
                             got.pcm, got.last, got.chunk_done, got.volume);
                end
                return;
            end
            want = pending_words.pop_front();
            if (got.pcm !== want.pcm || got.last !== want.last ||
                got.chunk_done !== want.chunk_done || got.volume !== want.volume) begin
                errors++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("pcm word mismatch at %0t: expected pcm=%0d last=%0b chunk=%0b vol=%0d, got pcm=%0d last=%0b chunk=%0b vol=%0d",
                             $realtime, want.pcm, want.last, want.chunk_done, want.volume,
                             got.pcm, got.last, got.chunk_done, got.volume);
                end
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data     = '0;
    logic                     i_valid        = 1'b0;
    logic                     o_ready;
    logic signed [I2S_W-1:0]  i_i2s_left     = '0;
    logic signed [I2S_W-1:0]  i_i2s_right    = '0;
    logic [ADC_W-1:0]         i_adc_sample_0 = '0;
    logic [ADC_W-1:0]         i_adc_sample_1 = '0;
    logic [ADC_W-1:0]         i_adc_sample_2 = '0;
    logic [ADC_W-1:0]         i_adc_sample_3 = '0;
    logic                     i_chunk_end    = 1'b0;
    logic                     o_valid;
    logic                     i_ready        = 1'b0;
    logic signed [PCM_W-1:0]  o_pcm_sample;
    logic                     o_last_of_frame;
    logic                     o_chunk_done;
    logic [VOL_W-1:0]         o_volume_level;

    mixer_mirror mirror = new();
    int          tx_idle_pct = 16;
    int          rx_idle_pct = 53;
    int          quiet_cycles = 0;
    int          sent_frames = 0;

    mic_sample_gain_mixer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_i2s_left      (i_i2s_left),
        .i_i2s_right     (i_i2s_right),
        .i_adc_sample_0  (i_adc_sample_0),
        .i_adc_sample_1  (i_adc_sample_1),
        .i_adc_sample_2  (i_adc_sample_2),
        .i_adc_sample_3  (i_adc_sample_3),
        .i_chunk_end     (i_chunk_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pcm_sample    (o_pcm_sample),
        .o_last_of_frame (o_last_of_frame),
        .o_chunk_done    (o_chunk_done),
        .o_volume_level  (o_volume_level)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            mirror.check_word('{o_pcm_sample, o_last_of_frame, o_chunk_done, o_volume_level});
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_frame mk_frame(logic [31:0] l, logic [31:0] r,
                                        logic [ADC_W-1:0] a0, logic [ADC_W-1:0] a1,
                                        logic [ADC_W-1:0] a2, logic [ADC_W-1:0] a3,
                                        logic ce);
        t_frame f;
        f.left      = l;
        f.right     = r;
        f.adc[0]    = a0;
        f.adc[1]    = a1;
        f.adc[2]    = a2;
        f.adc[3]    = a3;
        f.chunk_end = ce;
        return f;
    endfunction

    function automatic logic [31:0] rand_i2s();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(32'h03FF_FFFF);
            2: v = $urandom_range(32'h0001_FFFF);
            default: begin
                case ($urandom_range(5))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h0000_0800;
                    default: v = 32'hFFFF_F800;
                endcase
            end
        endcase
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    function automatic logic [ADC_W-1:0] rand_adc();
        logic [ADC_W-1:0] v;
        case ($urandom_range(3))
            0: v = ADC_W'($urandom_range(2048 + 64, 2048 - 64));
            1: v = $urandom_range(1) ? '1 : '0;
            default: v = ADC_W'($urandom_range(4095));
        endcase
        return v;
    endfunction

    function automatic t_frame rand_frame();
        t_frame f;
        f.left  = rand_i2s();
        f.right = rand_i2s();
        for (int m = 0; m < ADC_LANES; m++) f.adc[m] = rand_adc();
        f.chunk_end = ($urandom_range(7) == 0);
        return f;
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.source_mode = 2'($urandom_range(3));
        c.stereo_out  = 1'($urandom_range(1));
        case ($urandom_range(3))
            0: c.master_gain = '0;
            1: c.master_gain = '1;
            2: c.master_gain = GAIN_W'($urandom_range(7));
            default: c.master_gain = GAIN_W'($urandom_range(255));
        endcase
        c.blend_weight = ($urandom_range(9) == 0) ? WEIGHT_W'($urandom_range(127, 101))
                                                  : WEIGHT_W'($urandom_range(100));
        c.mic_count = 3'($urandom_range(7));
        case ($urandom_range(3))
            0: c.mic_gains = $urandom;
            1: c.mic_gains = $urandom & 32'h0303_0303;
            2: c.mic_gains = '0;
            default: c.mic_gains = '1;
        endcase
        return c;
    endfunction

    task automatic send_frame(input t_frame f);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_i2s_left     <= f.left;
        i_i2s_right    <= f.right;
        i_adc_sample_0 <= f.adc[0];
        i_adc_sample_1 <= f.adc[1];
        i_adc_sample_2 <= f.adc[2];
        i_adc_sample_3 <= f.adc[3];
        i_chunk_end    <= f.chunk_end;
        do @(posedge i_clk); while (!o_ready);
        mirror.note_frame(f);
    endtask

    // hold frames back until every pcm word is out, then load all registers
    task automatic start_phase(input t_cfg c);
        logic [CFG_IDX_W-1:0] regs[6] = '{REG_SOURCE_MODE, REG_STEREO_OUT, REG_MASTER_GAIN,
                                          REG_BLEND_WEIGHT, REG_MIC_COUNT, REG_MIC_GAINS};
        logic [CFG_DATA_W-1:0] val;
        i_valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        for (int k = 0; k < 6; k++) begin
            case (regs[k])
                REG_SOURCE_MODE:  val = CFG_DATA_W'(c.source_mode);
                REG_STEREO_OUT:   val = CFG_DATA_W'(c.stereo_out);
                REG_MASTER_GAIN:  val = CFG_DATA_W'(c.master_gain);
                REG_BLEND_WEIGHT: val = CFG_DATA_W'(c.blend_weight);
                REG_MIC_COUNT:    val = CFG_DATA_W'(c.mic_count);
                default:          val = c.mic_gains;
            endcase
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= val;
            @(posedge i_clk);
            mirror.set_reg(regs[k], val);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        t_cfg c;
        int   seg_len;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        c = CFG_RESET;
        start_phase(c);
        send_frame(mk_frame(32'h7FFF_FFFF, 32'h8000_0000, 12'd0, 12'd4095, 12'd2048, 12'd1, 1'b0));
        send_frame(mk_frame(32'h8000_0000, 32'h8000_0000, 12'd4095, 12'd0, 12'd1, 12'd2048, 1'b1));
        send_frame(mk_frame(32'h0000_0000, 32'hFFFF_FFFF, 12'd2048, 12'd2048, 12'd0, 12'd0, 1'b1));

        c.stereo_out  = 1'b1;
        c.master_gain = 8'd0;
        start_phase(c);
        send_frame(mk_frame(32'hFFFF_F800, 32'h0000_07FF, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0));
        send_frame(mk_frame(32'hFFFF_FFFF, 32'h7FFF_FFFF, 12'd4095, 12'd4095, 12'd0, 12'd0, 1'b1));

        c = '{MODE_ADC, 1'b0, 8'd255, 7'd60, 3'd4, 32'hFF00_0100};
        start_phase(c);
        send_frame(mk_frame(32'h1234_5678, 32'h8765_4321, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0));
        send_frame(mk_frame(32'h0000_0000, 32'h0000_0000, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0));
        send_frame(mk_frame(32'h7FFF_FFFF, 32'h8000_0000, 12'd2048, 12'd2048, 12'd2048, 12'd2048, 1'b1));
        send_frame(mk_frame(32'h0000_0000, 32'h0000_0000, 12'd2047, 12'd2049, 12'd0, 12'd4095, 1'b1));

        c = '{MODE_ADC, 1'b0, 8'd0, 7'd60, 3'd0, 32'h0000_0000};
        start_phase(c);
        send_frame(mk_frame(32'h0000_0000, 32'h0000_0000, 12'd2049, 12'd0, 12'd0, 12'd0, 1'b0));
        send_frame(mk_frame(32'h0000_0000, 32'h0000_0000, 12'd2047, 12'd4095, 12'd4095, 12'd4095, 1'b1));

        c = '{MODE_ADC, 1'b1, 8'd3, 7'd60, 3'd3, 32'h0102_0304};
        start_phase(c);
        send_frame(mk_frame(32'h0000_0000, 32'h0000_0000, 12'd2050, 12'd2040, 12'd2100, 12'd0, 1'b0));
        send_frame(mk_frame(32'h0000_0000, 32'h0000_0000, 12'd2045, 12'd2051, 12'd2047, 12'd4095, 1'b1));

        c = '{MODE_HYBRID, 1'b0, 8'd1, 7'd0, 3'd7, 32'h0403_0201};
        start_phase(c);
        send_frame(mk_frame(32'h0123_4567, 32'hFEDC_BA98, 12'd3000, 12'd1000, 12'd2048, 12'd100, 1'b0));
        send_frame(mk_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1));

        c = '{MODE_HYBRID, 1'b1, 8'd2, 7'd100, 3'd2, 32'h0000_0000};
        start_phase(c);
        send_frame(mk_frame(32'h0040_0000, 32'hFFC0_0000, 12'd4095, 12'd0, 12'd0, 12'd0, 1'b0));

        c.blend_weight = 7'd127;
        start_phase(c);
        send_frame(mk_frame(32'hFFF0_0000, 32'h0002_0000, 12'd1024, 12'd3072, 12'd0, 12'd0, 1'b0));
        send_frame(mk_frame(32'h0000_5000, 32'hFFFF_B000, 12'd2040, 12'd2060, 12'd0, 12'd0, 1'b1));

        c = '{2'd3, 1'b1, 8'd6, 7'd60, 3'd1, 32'h0606_0606};
        start_phase(c);
        send_frame(mk_frame(32'h0123_0000, 32'hFF00_0000, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0));
        send_frame(mk_frame(32'hFF80_0000, 32'h0000_0800, 12'd4095, 12'd0, 12'd0, 12'd0, 1'b1));

        c = '{MODE_HYBRID, 1'b0, 8'd0, 7'd37, 3'd2, 32'hFFFF_FFFF};
        start_phase(c);
        send_frame(mk_frame(32'h0100_0000, 32'hFF00_0000, 12'd2100, 12'd1990, 12'd0, 12'd0, 1'b1));

        while (sent_frames < RANDOM_FRAMES) begin
            if (sent_frames < RANDOM_FRAMES / 3) begin
                tx_idle_pct = 16;
                rx_idle_pct = 53;
            end else if (sent_frames < 2 * RANDOM_FRAMES / 3) begin
                tx_idle_pct = 53;
                rx_idle_pct = 16;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            seg_len = $urandom_range(80, 20);
            start_phase(rand_cfg());
            for (int k = 0; k < seg_len && sent_frames < RANDOM_FRAMES; k++) begin
                send_frame(rand_frame());
                sent_frames++;
            end
        end

        i_valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/msgm_pkg.sv
sv/msgm_front.sv
sv/msgm_queue.sv
sv/msgm_back.sv
sv/mic_sample_gain_mixer_core.sv
bench/tb.sv
